// ===== src/soe_pkg.sv =====
// Shared types, constants and codes for the sprite attribute store and line evaluation.
`default_nettype none
package soe_pkg;

  localparam int DEF_NUM_SPRITES = 64;
  localparam int DEF_NUM_SLOTS   = 8;

  localparam int ADDR_W   = 8;
  localparam int ROW_W    = 6;
  localparam int ROWS     = 64;
  localparam int LANES    = 4;
  localparam int LANE_W   = 2;
  localparam int LINE_W   = 9;
  localparam int OP_W     = 3;
  localparam int SLOT_IDX_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [7:0] EMPTY_BYTE   = 8'hFF;
  localparam logic [4:0] HEIGHT_SHORT = 5'd8;
  localparam logic [4:0] HEIGHT_TALL  = 5'd16;

  localparam logic CFG_TALL = 1'b0;
  localparam logic CFG_REND = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SET_ADDR = 3'd0,
    OP_WRITE    = 3'd1,
    OP_READ     = 3'd2,
    OP_EVAL     = 3'd3,
    OP_CLEAR    = 3'd4
  } soe_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } soe_state_t;

  // lane 0 = Y, 1 = tile, 2 = attribute, 3 = X
  typedef logic [LANES-1:0][7:0] soe_row_t;

  typedef struct packed {
    logic start;
    logic step;
    logic first;
    logic clr_ovf;
  } soe_scan_ctl_t;

  typedef struct packed {
    logic                  overflow_flag;
    logic                  zero_on_line;
    logic [7:0]            slot_x;
    logic [7:0]            slot_attr;
    logic [7:0]            slot_tile;
    logic [7:0]            slot_y;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [7:0]            read_data;
  } soe_result_t;

endpackage
`default_nettype wire

// ===== src/soe_store.sv =====
// Attribute store: four byte lanes of sprite rows, byte write, row read, row valid bits.
`default_nettype none
module soe_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [soe_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]               wr_data,
  input  wire logic [soe_pkg::ROW_W-1:0] rd_row,
  output soe_pkg::soe_row_t             rd_bytes
);
  import soe_pkg::*;

  logic [ROWS-1:0]       row_valid_r;
  logic                  rd_valid_r;
  soe_row_t              rd_q_r;
  logic [ROW_W-1:0]      wr_row;
  logic [LANE_W-1:0]     wr_lane;

  assign wr_row  = wr_addr[ADDR_W-1:LANE_W];
  assign wr_lane = wr_addr[LANE_W-1:0];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [7:0] mem [ROWS];
    logic       lane_hit;

    assign lane_hit = (wr_lane == LANE_W'(g));

    always_ff @(posedge clk) begin
      if (wr_en) begin
        if (lane_hit) begin
          mem[wr_row] <= wr_data;
        end else if (!row_valid_r[wr_row]) begin
          mem[wr_row] <= '0;
        end
      end
      rd_q_r[g] <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_row] <= 1'b1;
      end
      rd_valid_r <= row_valid_r[rd_row];
    end
  end

  assign rd_bytes = rd_valid_r ? rd_q_r : '0;

endmodule
`default_nettype wire

// ===== src/soe_scan.sv =====
// Line coverage test, secondary slot buffer, sprite 0 and overflow flags.
`default_nettype none
module soe_scan #(
  parameter int NUM_SLOTS = soe_pkg::DEF_NUM_SLOTS,
  parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  soe_pkg::soe_scan_ctl_t         ctl,
  input  wire logic                      tall,
  input  wire logic                      rendering,
  input  wire logic [soe_pkg::LINE_W-1:0] line,
  input  soe_pkg::soe_row_t              sprite,
  input  wire logic [SLOT_W-1:0]         sel,
  output soe_pkg::soe_row_t              slot_word,
  output logic                           zero_seen,
  output logic                           overflow
);
  import soe_pkg::*;

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [LINE_W-1:0] line_r;
  logic [CNT_W-1:0]  used_r;
  logic              zero_r;
  logic              ovf_r;
  soe_row_t          slot_r [NUM_SLOTS];
  logic [LINE_W:0]   diff;
  logic [4:0]        height;
  logic              covers;
  logic              full;

  assign diff   = {1'b0, line_r} - {2'b00, sprite[0]};
  assign height = tall ? HEIGHT_TALL : HEIGHT_SHORT;
  assign covers = !diff[LINE_W] && (diff != '0) &&
                  (diff[LINE_W-1:0] <= {{(LINE_W-5){1'b0}}, height});
  assign full   = (used_r == CNT_W'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      line_r <= line;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= {LANES{EMPTY_BYTE}};
      end
    end else if (ctl.step && covers && !full) begin
      slot_r[used_r[SLOT_W-1:0]] <= sprite;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      zero_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      if (ctl.start) begin
        used_r <= '0;
        zero_r <= 1'b0;
      end else if (ctl.step && covers) begin
        if (ctl.first) begin
          zero_r <= 1'b1;
        end
        if (!full) begin
          used_r <= used_r + CNT_W'(1);
        end else if (rendering) begin
          ovf_r <= 1'b1;
        end
      end
      if (ctl.clr_ovf) begin
        ovf_r <= 1'b0;
      end
    end
  end

  assign slot_word = slot_r[sel];
  assign zero_seen = zero_r;
  assign overflow  = ovf_r;

endmodule
`default_nettype wire

// ===== src/sprite_oam_evaluation.sv =====
// Sprite attribute store with per-line sprite evaluation (top level).
//
// Input stream: in_tuser carries the op, in_tdata the data byte and scanline.
// Output stream: one beat per op, eight slot beats (NUM_SLOTS) for an evaluate,
// with out_tlast on the final beat of each op.
// Set address, write, clear overflow and unused ops: the result beat is
// registered at the accept edge and shows in the next cycle.
// Read: the store registers the row, then the output register takes the byte.
// Evaluate: the store reads the first sprite row on accept, the scan then steps
// through NUM_SPRITES rows, then NUM_SLOTS beats follow, one a cycle while the
// receiver takes them. The scan reads one sprite row of four bytes per cycle
// from the store.
// One op is in work at a time; a new op is taken once the output register is
// free or being emptied.
// Reset clears the address, flags and configuration; the store reads as zero
// through per-row valid bits, so no clearing pass is needed.
// A stalled receiver holds the output register and stalls the slot beats.
`default_nettype none
module sprite_oam_evaluation #(
  parameter int NUM_SPRITES = soe_pkg::DEF_NUM_SPRITES,
  parameter int NUM_SLOTS   = soe_pkg::DEF_NUM_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // data[7:0], scanline[16:8]
  input  wire logic [soe_pkg::IN_TDATA_W-1:0] in_tdata,
  // op[2:0]
  input  wire logic [soe_pkg::OP_W-1:0]       in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // read_data[7:0], slot_index[10:8], slot_y[18:11], slot_tile[26:19],
  // slot_attr[34:27], slot_x[42:35], zero_on_line[43], overflow_flag[44]
  output logic [soe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic                           cfg_wdata
);
  import soe_pkg::*;

  localparam int SPR_W  = $clog2(NUM_SPRITES);
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RES_W  = $bits(soe_result_t);

  soe_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [SPR_W-1:0]  scan_cnt_r;
  logic [SLOT_W-1:0] emit_cnt_r;
  logic              tall_r;
  logic              rend_r;
  logic              out_valid_r;
  logic              out_last_r;
  soe_result_t       out_res_r;

  soe_op_t           in_op;
  logic [7:0]        in_data;
  logic [LINE_W-1:0] in_line;
  logic              out_free;
  logic              accept;
  logic              scan_last;
  logic              emit_last;

  logic              wr_en;
  logic [ROW_W-1:0]  rd_row;
  soe_row_t          rd_bytes;
  soe_scan_ctl_t     ctl;
  soe_row_t          slot_word;
  logic              zero_seen;
  logic              overflow;
  logic              load_out;
  logic              last_nxt;
  soe_result_t       res_nxt;

  assign in_op     = soe_op_t'(in_tuser);
  assign in_data   = in_tdata[7:0];
  assign in_line   = in_tdata[16:8];
  assign out_free  = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign scan_last = (scan_cnt_r == SPR_W'(NUM_SPRITES - 1));
  assign emit_last = (emit_cnt_r == SLOT_W'(NUM_SLOTS - 1));

  soe_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (addr_r),
    .wr_data  (in_data),
    .rd_row   (rd_row),
    .rd_bytes (rd_bytes)
  );

  soe_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .tall      (tall_r),
    .rendering (rend_r),
    .line      (in_line),
    .sprite    (rd_bytes),
    .sel       (emit_cnt_r),
    .slot_word (slot_word),
    .zero_seen (zero_seen),
    .overflow  (overflow)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            state_nxt = ST_READ;
          end else if (in_op == OP_EVAL) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    rd_row    = addr_r[ADDR_W-1:LANE_W];
    ctl       = '0;
    load_out  = 1'b0;
    last_nxt  = 1'b1;
    res_nxt   = '0;
    res_nxt.zero_on_line  = zero_seen;
    res_nxt.overflow_flag = overflow;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        if (accept) begin
          unique case (in_op)
            OP_WRITE: begin
              wr_en    = 1'b1;
              load_out = 1'b1;
            end
            OP_READ: ;
            OP_EVAL: begin
              rd_row    = '0;
              ctl.start = 1'b1;
            end
            OP_CLEAR: begin
              ctl.clr_ovf           = 1'b1;
              res_nxt.overflow_flag = 1'b0;
              load_out              = 1'b1;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        load_out          = 1'b1;
        res_nxt.read_data = rd_bytes[addr_r[LANE_W-1:0]];
      end
      ST_SCAN: begin
        rd_row    = ROW_W'({1'b0, scan_cnt_r} + (SPR_W + 1)'(1));
        ctl.step  = 1'b1;
        ctl.first = (scan_cnt_r == '0);
      end
      ST_EMIT: begin
        load_out           = out_free;
        last_nxt           = emit_last;
        res_nxt.slot_index = SLOT_IDX_W'(emit_cnt_r);
        res_nxt.slot_y     = slot_word[0];
        res_nxt.slot_tile  = slot_word[1];
        res_nxt.slot_attr  = slot_word[2];
        res_nxt.slot_x     = slot_word[3];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      scan_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      tall_r      <= 1'b0;
      rend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_op == OP_SET_ADDR) begin
        addr_r <= in_data;
      end else if (wr_en) begin
        addr_r <= addr_r + ADDR_W'(1);
      end
      if (ctl.start) begin
        scan_cnt_r <= '0;
        emit_cnt_r <= '0;
      end else begin
        if (ctl.step) begin
          scan_cnt_r <= scan_cnt_r + SPR_W'(1);
        end
        if (state_r == ST_EMIT && load_out) begin
          emit_cnt_r <= emit_cnt_r + SLOT_W'(1);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_TALL) begin
          tall_r <= cfg_wdata;
        end else if (cfg_index == CFG_REND) begin
          rend_r <= cfg_wdata;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r  <= res_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res_r};
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire
